// ===== rtl/core/mnpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the note priority tracker.
// No dependencies; imported by mnpt_held_stack and the top level.
package mnpt_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int KEY_MAX         = 127;
  localparam int SHIFT_MAX       = 48;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // input op codes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_ALL_OFF  = 2'd2;

  // output event kinds
  localparam logic [1:0] EV_VOICE_ON  = 2'd0;
  localparam logic [1:0] EV_VOICE_OFF = 2'd1;
  localparam logic [1:0] EV_ALL_OFF   = 2'd2;

  // register word indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MONO    = 3'd0;
  localparam logic [2:0] REG_SHIFT   = 3'd1;
  localparam logic [2:0] REG_LOW     = 3'd2;
  localparam logic [2:0] REG_HIGH    = 3'd3;
  localparam logic [2:0] REG_CHANNEL = 3'd4;

  typedef enum logic [1:0] {
    STK_OP_PUSH,
    STK_OP_REMOVE,
    STK_OP_CLEAR
  } stk_op_t;

  typedef enum logic [2:0] {
    STK_IDLE,
    STK_SEARCH,
    STK_SHIFT,
    STK_ERASE,
    STK_DONE
  } stk_state_t;

  typedef enum logic [1:0] {
    TRK_IDLE,
    TRK_WAIT,
    TRK_EMIT0,
    TRK_EMIT1
  } trk_state_t;

  typedef struct packed {
    logic       start;
    stk_op_t    op;
    logic [6:0] key;
  } stk_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       nonempty;
    logic [6:0] top;
  } stk_stat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] key;
    logic [6:0] vel;
    logic       last;
  } result_t;

  // transpose by a saturated shift, clamp to the MIDI key range
  function automatic logic [6:0] shift_key(input logic [6:0] k, input logic [6:0] s);
    logic signed [8:0] sx;
    logic signed [8:0] sat;
    logic signed [8:0] t;
    logic [6:0]        r;
    sx = 9'($signed(s));
    if (sx > 9'(SHIFT_MAX)) begin
      sat = 9'(SHIFT_MAX);
    end else if (sx < -9'(SHIFT_MAX)) begin
      sat = -9'(SHIFT_MAX);
    end else begin
      sat = sx;
    end
    t = $signed({2'b00, k}) + sat;
    if (t < 9'sd0) begin
      r = '0;
    end else if (t > 9'(KEY_MAX)) begin
      r = 7'(KEY_MAX);
    end else begin
      r = t[6:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mnpt_held_stack.sv =====
`timescale 1ns / 1ps
// Held-key stack: one-port-read synchronous memory, fill count and scan sequencer.
// Depends on mnpt_pkg.
module mnpt_held_stack import mnpt_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  stk_state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [6:0]    top;
  logic [6:0]    key_r;
  logic [6:0]    mem_q;
  logic [6:0]    mem [STACK_DEPTH];

  logic          scanning;
  logic          issue;
  logic          scan_done;
  logic          match;
  logic          hit;
  logic          we;
  logic [IW-1:0] waddr;
  logic [6:0]    wdata;

  always_comb begin
    scanning  = (state == STK_SEARCH) || (state == STK_SHIFT) || (state == STK_ERASE);
    scan_done = (rd_idx == count) && !pend;
    match     = (state == STK_SHIFT) ? (pend_idx == '0) : (mem_q == key_r);
    hit       = pend && !found && match;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      STK_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.op)
            STK_OP_PUSH:   state_next = STK_SEARCH;
            STK_OP_REMOVE: state_next = STK_ERASE;
            STK_OP_CLEAR:  state_next = STK_DONE;
            default:       state_next = STK_IDLE;
          endcase
        end
      end
      STK_SEARCH: begin
        if (scan_done) begin
          state_next = (!found && count == FULL) ? STK_SHIFT : STK_DONE;
        end
      end
      STK_SHIFT, STK_ERASE: begin
        if (scan_done) begin
          state_next = STK_DONE;
        end
      end
      STK_DONE: state_next = STK_IDLE;
      default:  state_next = STK_IDLE;
    endcase
  end

  always_comb begin
    issue = scanning && (rd_idx != count);
    we    = 1'b0;
    waddr = pend_idx - 1'b1;
    wdata = mem_q;
    if ((state == STK_SHIFT || state == STK_ERASE) && pend && found) begin
      we = 1'b1;
    end
    if (state == STK_SEARCH && scan_done && !found && count != FULL) begin
      we    = 1'b1;
      waddr = count[IW-1:0];
      wdata = key_r;
    end
    if (state == STK_SHIFT && scan_done) begin
      we    = 1'b1;
      waddr = IW'(count - 1'b1);
      wdata = key_r;
    end
    stat.busy     = (state != STK_IDLE);
    stat.done     = (state == STK_DONE);
    stat.nonempty = (count != '0);
    stat.top      = top;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= STK_IDLE;
      count  <= '0;
      rd_idx <= '0;
      pend   <= 1'b0;
      found  <= 1'b0;
    end else begin
      state    <= state_next;
      pend     <= issue;
      pend_idx <= rd_idx[IW-1:0];
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
      end
      if (pend && !hit) begin
        top <= mem_q;
      end
      if (state == STK_IDLE && cmd.start) begin
        rd_idx <= '0;
        found  <= 1'b0;
        key_r  <= cmd.key;
        if (cmd.op == STK_OP_CLEAR) begin
          count <= '0;
        end
      end
      if (state == STK_SEARCH && scan_done && !found) begin
        if (count == FULL) begin
          rd_idx <= '0;
          found  <= 1'b0;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (state == STK_ERASE && scan_done && found) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/midi_note_priority_tracker_unit.sv =====
`timescale 1ns / 1ps
// MIDI note priority tracker: register port, event sequencer, output register.
// Depends on mnpt_pkg and mnpt_held_stack.
//
// Usage:
//   Note words (op, key, strike) enter on note_valid/note_ready. Each word
//   gives zero, one or two voice words on voice_valid/voice_ready; the last
//   word of a run carries last_of_run. Registers are written over the APB
//   port (pready tied high); the user must write them only while the block
//   is idle, as the block itself does not enforce it. One word is worked on
//   at a time. The held-key memory is scanned one entry a cycle through a
//   registered read; a note-on whose key is not held and that finds the
//   stack full adds a second pass that drops the oldest entry.
//   A voice word waits in an output register; while it is stalled the next
//   note word is still accepted and worked on up to the point of output.
//   Reset empties the stack, silences the voice and loads register defaults
//   (poly mode, no shift, full key range, channel 0).
module midi_note_priority_tracker_unit import mnpt_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              note_valid,
  output logic              note_ready,
  input  logic [1:0]        op,
  input  logic [6:0]        key,
  input  logic [6:0]        strike,
  output logic              voice_valid,
  input  logic              voice_ready,
  output logic [1:0]        event_kind,
  output logic [6:0]        out_key,
  output logic [6:0]        out_velocity,
  output logic [3:0]        out_channel,
  output logic              last_of_run
);

  logic       mono_mode;
  logic [6:0] semitone_shift;
  logic [6:0] range_low;
  logic [6:0] range_high;
  logic [3:0] channel_id;

  trk_state_t state, state_next;

  logic [1:0] op_r;
  logic [6:0] key_r;
  logic [6:0] strike_r;
  logic       legato;
  logic [6:0] sounding_key, sounding_key_next;
  logic       sounding_valid, sounding_valid_next;
  logic [6:0] sounding_velocity, sounding_velocity_next;
  result_t    res0, res0_next;
  result_t    res1, res1_next;
  logic       res_two, res_two_next;
  logic       res_any;
  result_t    out_r;
  logic [3:0] chan_r;

  stk_cmd_t   stk_cmd;
  stk_stat_t  stk_stat;

  logic       cfg_we;
  logic       note_accept;
  logic       out_free;
  logic       load;
  logic [6:0] lo, hi;
  logic       in_range;
  logic       off_hit;
  logic [6:0] k0, k1;

  mnpt_held_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .stat(stk_stat)
  );

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode      <= 1'b0;
      semitone_shift <= '0;
      range_low      <= '0;
      range_high     <= 7'(KEY_MAX);
      channel_id     <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_MONO:    mono_mode      <= pwdata[0];
        REG_SHIFT:   semitone_shift <= pwdata[6:0];
        REG_LOW:     range_low      <= pwdata[6:0];
        REG_HIGH:    range_high     <= pwdata[6:0];
        REG_CHANNEL: channel_id     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MONO:    prdata = DATA_W'(mono_mode);
      REG_SHIFT:   prdata = DATA_W'(semitone_shift);
      REG_LOW:     prdata = DATA_W'(range_low);
      REG_HIGH:    prdata = DATA_W'(range_high);
      REG_CHANNEL: prdata = DATA_W'(channel_id);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    lo       = (range_low < range_high) ? range_low : range_high;
    hi       = (range_low < range_high) ? range_high : range_low;
    in_range = (key >= lo) && (key <= hi);
    out_free = !voice_valid || voice_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      TRK_IDLE:  if (note_accept && stk_cmd.start) state_next = TRK_WAIT;
      TRK_WAIT:  if (stk_stat.done) state_next = res_any ? TRK_EMIT0 : TRK_IDLE;
      TRK_EMIT0: if (out_free) state_next = res_two ? TRK_EMIT1 : TRK_IDLE;
      TRK_EMIT1: if (out_free) state_next = TRK_IDLE;
      default:   state_next = TRK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    note_ready    = (state == TRK_IDLE);
    note_accept   = note_valid && note_ready;
    stk_cmd.key   = key;
    stk_cmd.start = 1'b0;
    stk_cmd.op    = STK_OP_PUSH;
    case (op)
      OP_NOTE_ON:  stk_cmd.start = note_accept && in_range;
      OP_NOTE_OFF: begin
        stk_cmd.start = note_accept;
        stk_cmd.op    = STK_OP_REMOVE;
      end
      OP_ALL_OFF:  begin
        stk_cmd.start = note_accept;
        stk_cmd.op    = STK_OP_CLEAR;
      end
      default: ;
    endcase
    load = ((state == TRK_EMIT0) || (state == TRK_EMIT1)) && out_free;
  end

  // result and sounding-note resolution once the stack pass is done
  always_comb begin
    off_hit = sounding_valid && (key_r == sounding_key);
    k0 = shift_key((op_r == OP_NOTE_ON && legato) ? sounding_key : key_r, semitone_shift);
    k1 = shift_key((op_r == OP_NOTE_ON) ? key_r : stk_stat.top, semitone_shift);
    res0_next              = '{kind: EV_VOICE_OFF, key: k0, vel: 7'd0, last: 1'b1};
    res1_next              = '{kind: EV_VOICE_ON, key: k1, vel: sounding_velocity, last: 1'b1};
    res_two_next           = 1'b0;
    res_any                = 1'b1;
    sounding_key_next      = sounding_key;
    sounding_valid_next    = sounding_valid;
    sounding_velocity_next = sounding_velocity;
    case (op_r)
      OP_NOTE_ON: begin
        sounding_key_next      = key_r;
        sounding_valid_next    = 1'b1;
        sounding_velocity_next = strike_r;
        res1_next.vel          = strike_r;
        if (legato) begin
          res0_next.last = 1'b0;
          res_two_next   = 1'b1;
        end else begin
          res0_next = res1_next;
        end
      end
      OP_NOTE_OFF: begin
        if (mono_mode) begin
          if (off_hit) begin
            if (stk_stat.nonempty) begin
              sounding_key_next = stk_stat.top;
              res0_next.last    = 1'b0;
              res_two_next      = 1'b1;
            end else begin
              sounding_valid_next = 1'b0;
            end
          end else begin
            res_any = 1'b0;
          end
        end else begin
          if (!stk_stat.nonempty) begin
            sounding_valid_next = 1'b0;
          end else if (off_hit) begin
            sounding_key_next = stk_stat.top;
          end
        end
      end
      OP_ALL_OFF: begin
        res0_next           = '{kind: EV_ALL_OFF, key: 7'd0, vel: 7'd0, last: 1'b1};
        sounding_valid_next = 1'b0;
      end
      default: res_any = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= TRK_IDLE;
      sounding_key      <= '0;
      sounding_valid    <= 1'b0;
      sounding_velocity <= '0;
      voice_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (note_accept) begin
        op_r     <= op;
        key_r    <= key;
        strike_r <= strike;
        legato   <= mono_mode && stk_stat.nonempty && sounding_valid;
      end
      if (state == TRK_WAIT && stk_stat.done) begin
        sounding_key      <= sounding_key_next;
        sounding_valid    <= sounding_valid_next;
        sounding_velocity <= sounding_velocity_next;
        res0              <= res0_next;
        res1              <= res1_next;
        res_two           <= res_two_next;
      end
      if (load) begin
        voice_valid <= 1'b1;
        out_r       <= (state == TRK_EMIT1) ? res1 : res0;
        chan_r      <= channel_id;
      end else if (voice_ready) begin
        voice_valid <= 1'b0;
      end
    end
  end

  assign event_kind   = out_r.kind;
  assign out_key      = out_r.key;
  assign out_velocity = out_r.vel;
  assign out_channel  = chan_r;
  assign last_of_run  = out_r.last;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stk_stat.done |-> (state == TRK_WAIT))
    else $error("stack pass finished outside of wait state");

  a_accept_stack_idle: assert property (@(posedge clk) disable iff (rst)
    note_accept |-> !stk_stat.busy)
    else $error("note word taken while the stack is busy");

  a_note_on_sounds: assert property (@(posedge clk) disable iff (rst)
    (state == TRK_WAIT && stk_stat.done && op_r == OP_NOTE_ON) |=> sounding_valid)
    else $error("note on left no note sounding");
`endif

endmodule

// ===== sim/midi_note_priority_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midi_note_priority_tracker_unit: predicts voice words
// per accepted note word and checks them in order. Depends on mnpt_pkg and the RTL.
module midi_note_priority_tracker_unit_tb;
  import mnpt_pkg::*;

  localparam int         DEPTH       = DEF_STACK_DEPTH;
  localparam int         SETTLE      = 2 * DEPTH + 24;
  localparam int         LONG_STALL  = 300;
  localparam int         PRINT_LIMIT = 40;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] key;
    logic [6:0] strike;
  } note_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] key;
    logic [6:0] vel;
    logic [3:0] chan;
    logic       last;
  } voice_word_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              note_valid = 1'b0;
  logic              note_ready;
  logic [1:0]        op = '0;
  logic [6:0]        key = '0;
  logic [6:0]        strike = '0;
  logic              voice_valid;
  logic              voice_ready = 1'b0;
  logic [1:0]        event_kind;
  logic [6:0]        out_key;
  logic [6:0]        out_velocity;
  logic [3:0]        out_channel;
  logic              last_of_run;

  midi_note_priority_tracker_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .note_valid, .note_ready, .op, .key, .strike,
    .voice_valid, .voice_ready, .event_kind, .out_key, .out_velocity,
    .out_channel, .last_of_run
  );

  // register shadow, reset values
  logic              cfg_mono = 1'b0;
  logic signed [6:0] cfg_shift = '0;
  logic [6:0]        cfg_low = 7'd0;
  logic [6:0]        cfg_high = 7'd127;
  logic [3:0]        cfg_chan = 4'd0;

  // tracker state
  logic [6:0] held_keys[$];
  logic [6:0] snd_key = '0;
  logic [6:0] snd_vel = '0;
  logic       snd_valid = 1'b0;

  note_word_t  notes_in[$];
  voice_word_t voices_due[$];
  note_word_t  cur_note;
  voice_word_t got_want;

  int  notes_sent = 0;
  int  notes_taken = 0;
  int  live_notes = 0;
  int  fails = 0;
  int  send_gap = 0;
  int  ready_gap = 0;
  int  stall_reqs = 0;
  int  stall_acks = 0;
  bit  idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[midi_note_priority_tracker_unit] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    if (fails < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic logic [6:0] transpose(input logic [6:0] k);
    int s;
    int t;
    s = cfg_shift;
    if (s > SHIFT_MAX) s = SHIFT_MAX;
    if (s < -SHIFT_MAX) s = -SHIFT_MAX;
    t = int'(k) + s;
    if (t < 0) t = 0;
    if (t > KEY_MAX) t = KEY_MAX;
    return 7'(t);
  endfunction

  function automatic voice_word_t voice(input logic [1:0] kind, input logic [6:0] k,
                                        input logic [6:0] v);
    voice_word_t w;
    w.kind = kind;
    w.key  = k;
    w.vel  = v;
    w.chan = cfg_chan;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic int held_pos(input logic [6:0] k);
    for (int i = 0; i < held_keys.size(); i++) if (held_keys[i] == k) return i;
    return -1;
  endfunction

  task automatic track_note(input logic [1:0] o, input logic [6:0] k, input logic [6:0] v);
    voice_word_t run[2];
    int          n;
    int          pos;
    logic [6:0]  lo;
    logic [6:0]  hi;
    n  = 0;
    lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
    hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
    case (o)
      OP_NOTE_ON: begin
        if (k >= lo && k <= hi) begin
          if (cfg_mono && held_keys.size() > 0 && snd_valid) begin
            run[n] = voice(EV_VOICE_OFF, transpose(snd_key), 7'd0);
            n++;
          end
          if (held_pos(k) < 0) begin
            if (held_keys.size() >= DEPTH) void'(held_keys.pop_front());
            held_keys = {held_keys, k};
          end
          snd_key   = k;
          snd_vel   = v;
          snd_valid = 1'b1;
          run[n] = voice(EV_VOICE_ON, transpose(k), v);
          n++;
        end
      end
      OP_NOTE_OFF: begin
        pos = held_pos(k);
        if (pos >= 0) held_keys.delete(pos);
        if (cfg_mono) begin
          if (snd_valid && k == snd_key) begin
            run[n] = voice(EV_VOICE_OFF, transpose(k), 7'd0);
            n++;
            if (held_keys.size() > 0) begin
              snd_key = held_keys[held_keys.size() - 1];
              run[n] = voice(EV_VOICE_ON, transpose(snd_key), snd_vel);
              n++;
            end else begin
              snd_valid = 1'b0;
            end
          end
        end else begin
          run[n] = voice(EV_VOICE_OFF, transpose(k), 7'd0);
          n++;
          if (held_keys.size() == 0) begin
            snd_valid = 1'b0;
          end else if (snd_valid && k == snd_key) begin
            snd_key = held_keys[held_keys.size() - 1];
          end
        end
      end
      OP_ALL_OFF: begin
        run[n] = voice(EV_ALL_OFF, 7'd0, 7'd0);
        n++;
        held_keys.delete();
        snd_valid = 1'b0;
      end
      default: ;
    endcase
    if (n > 0) run[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) voices_due = {voices_due, run[i]};
  endtask

  // note word driver
  always @(posedge clk) begin
    if (rst) begin
      note_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (note_valid && note_ready) begin
        track_note(op, key, strike);
        notes_taken++;
      end
      if (!note_valid || note_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          note_valid <= 1'b0;
        end else if (notes_in.size() > 0) begin
          cur_note = notes_in.pop_front();
          note_valid <= 1'b1;
          op <= cur_note.op;
          key <= cur_note.key;
          strike <= cur_note.strike;
          if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
        end else begin
          note_valid <= 1'b0;
        end
      end
    end
  end

  // voice word monitor
  always @(posedge clk) begin
    if (rst) begin
      voice_ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (voice_valid && voice_ready) begin
        if (voices_due.size() == 0) begin
          report($sformatf("voice word kind %0d key %0d with none expected",
                           event_kind, out_key));
        end else begin
          got_want = voices_due.pop_front();
          if (event_kind !== got_want.kind)
            report($sformatf("event_kind %0d, want %0d", event_kind, got_want.kind));
          if (out_key !== got_want.key)
            report($sformatf("out_key %0d, want %0d", out_key, got_want.key));
          if (out_velocity !== got_want.vel)
            report($sformatf("out_velocity %0d, want %0d", out_velocity, got_want.vel));
          if (out_channel !== got_want.chan)
            report($sformatf("out_channel %0d, want %0d", out_channel, got_want.chan));
          if (last_of_run !== got_want.last)
            report($sformatf("last_of_run %0b, want %0b", last_of_run, got_want.last));
        end
      end
      if (stall_acks != stall_reqs) begin
        stall_acks = stall_reqs;
        ready_gap  = LONG_STALL;
      end
      if (ready_gap > 0) begin
        ready_gap--;
        voice_ready <= 1'b0;
      end else begin
        voice_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) ready_gap = $urandom_range(1, 6);
      end
    end
  end

  task automatic put_note(input logic [1:0] o, input logic [6:0] k, input logic [6:0] v);
    note_word_t w;
    w.op     = o;
    w.key    = k;
    w.strike = v;
    notes_in = {notes_in, w};
    notes_sent++;
    if (o != OP_RESERVED) live_notes++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MONO:    cfg_mono = val[0];
      REG_SHIFT:   cfg_shift = val[6:0];
      REG_LOW:     cfg_low = val[6:0];
      REG_HIGH:    cfg_high = val[6:0];
      REG_CHANNEL: cfg_chan = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic m, input logic [6:0] s, input logic [6:0] lo,
                            input logic [6:0] hi, input logic [3:0] ch);
    reg_write(REG_MONO, DATA_W'(m));
    reg_write(REG_SHIFT, DATA_W'(s));
    reg_write(REG_LOW, DATA_W'(lo));
    reg_write(REG_HIGH, DATA_W'(hi));
    reg_write(REG_CHANNEL, DATA_W'(ch));
  endtask

  // all words accepted, all voice words seen, block given time to go idle
  task automatic drain();
    while (notes_taken != notes_sent || voices_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic play_phrase();
    int         pick;
    int         n;
    int         idx;
    int         base;
    logic [6:0] k;
    logic [6:0] chord[$];
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // short phrase around one register, keys may repeat
      n    = $urandom_range(1, 6);
      base = $urandom_range(0, 127);
      for (int i = 0; i < n; i++) begin
        k = 7'((base + $urandom_range(0, 12) > 127) ? 127 : base + $urandom_range(0, 12));
        chord = {chord, k};
        put_note(OP_NOTE_ON, k, 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 5) == 0)
          put_note(OP_NOTE_OFF, chord[$urandom_range(0, chord.size() - 1)],
                   7'($urandom_range(0, 127)));
      end
      while (chord.size() > 0) begin
        idx = $urandom_range(0, chord.size() - 1);
        k   = chord[idx];
        chord.delete(idx);
        if ($urandom_range(0, 7) != 0) put_note(OP_NOTE_OFF, k, 7'($urandom_range(0, 127)));
      end
    end else if (pick < 62) begin
      // fill the held stack, sometimes past its depth
      n = $urandom_range(DEPTH - 1, DEPTH + 4);
      for (int i = 0; i < n; i++) begin
        k = 7'($urandom_range(0, 127));
        chord = {chord, k};
        put_note(OP_NOTE_ON, k, 7'($urandom_range(0, 127)));
      end
      while (chord.size() > 0) begin
        idx = $urandom_range(0, chord.size() - 1);
        k   = chord[idx];
        chord.delete(idx);
        if ($urandom_range(0, 1) == 0) put_note(OP_NOTE_OFF, k, 7'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 1) == 0)
        put_note(OP_ALL_OFF, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end else if (pick < 70) begin
      put_note(OP_ALL_OFF, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end else if (pick < 73) begin
      put_note(OP_RESERVED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end else begin
      put_note(2'($urandom_range(0, 2)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int         goal;
    bit         paused;
    logic [6:0] lo;
    logic [6:0] hi;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // poly, reset settings
    put_note(OP_NOTE_ON, 7'd0, 7'd0);
    put_note(OP_NOTE_ON, 7'd127, 7'd127);
    put_note(OP_NOTE_ON, 7'd127, 7'd64);
    put_note(OP_NOTE_OFF, 7'd0, 7'd0);
    put_note(OP_NOTE_OFF, 7'd5, 7'd127);
    put_note(OP_ALL_OFF, 7'd127, 7'd127);
    put_note(OP_RESERVED, 7'd127, 7'd127);
    put_note(OP_NOTE_OFF, 7'd127, 7'd0);
    drain();

    // mono, shift past the limit, bounds given high-low
    set_config(1'b1, 7'h3F, 7'd100, 7'd20, 4'd15);
    put_note(OP_NOTE_ON, 7'd10, 7'd90);
    put_note(OP_NOTE_ON, 7'd20, 7'd100);
    put_note(OP_NOTE_ON, 7'd60, 7'd5);
    put_note(OP_NOTE_ON, 7'd100, 7'd127);
    put_note(OP_NOTE_ON, 7'd101, 7'd1);
    put_note(OP_NOTE_ON, 7'd60, 7'd33);
    put_note(OP_NOTE_OFF, 7'd20, 7'd0);
    put_note(OP_NOTE_OFF, 7'd60, 7'd0);
    put_note(OP_NOTE_OFF, 7'd100, 7'd0);
    put_note(OP_NOTE_OFF, 7'd100, 7'd0);
    put_note(OP_NOTE_ON, 7'd50, 7'd77);
    put_note(OP_ALL_OFF, 7'd0, 7'd0);
    put_note(OP_NOTE_OFF, 7'd50, 7'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1'b1, 7'h50, 7'd0, 7'd127, 4'd0);
        1: set_config(1'b0, 7'd48, 7'd127, 7'd0, 4'd15);
        2: set_config(1'b1, 7'h40, 7'd10, 7'd117, 4'd5);
        default: begin
          lo = 7'($urandom_range(0, 40));
          hi = 7'($urandom_range(80, 127));
          if ($urandom_range(0, 1) == 0) set_config(1'($urandom_range(0, 1)),
              7'($urandom_range(0, 127)), lo, hi, 4'($urandom_range(0, 15)));
          else set_config(1'($urandom_range(0, 1)),
              7'($urandom_range(0, 127)), hi, lo, 4'($urandom_range(0, 15)));
        end
      endcase
      idle_on = (ph != 7);
      if (ph == 2) stall_reqs++;
      goal = live_notes + 85;
      while (live_notes < goal) begin
        play_phrase();
        if (ph == 4 && !paused && live_notes > goal - 50) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    if (fails == 0) $display("[midi_note_priority_tracker_unit] OK");
    else $display("[midi_note_priority_tracker_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mnpt_pkg.sv
rtl/core/mnpt_held_stack.sv
rtl/core/midi_note_priority_tracker_unit.sv
sim/midi_note_priority_tracker_unit_tb.sv
